// ===== sv/track_format_stream_parser_defines.svh =====
// Assertion helpers for the track format stream parser.
`ifndef TRACK_FORMAT_STREAM_PARSER_DEFINES_SVH
`define TRACK_FORMAT_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TFSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tfsp_pkg.sv =====
package tfsp_pkg;

  // Track template marks
  localparam logic [7:0] MARK_SYNC     = 8'hF5;
  localparam logic [7:0] MARK_ID       = 8'hFE;
  localparam logic [7:0] MARK_DATA     = 8'hFB;
  localparam logic [7:0] MARK_DATA_DEL = 8'hF8;
  localparam logic [7:0] MARK_CRC      = 8'hF7;

  // ID field layout: four bytes, record number in the third
  localparam logic [2:0] ID_LEN        = 3'd4;
  localparam logic [2:0] ID_RECORD_POS = 3'd2;

  // Result kinds carried on tuser
  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_COMMIT = 1'b1
  } kind_t;

  // Result word fields
  typedef struct packed {
    logic [7:0] byte_value;
    logic [8:0] byte_offset;
    logic [7:0] sector_number;
  } result_t;

  localparam int unsigned OUT_TDATA_W = 32;

endpackage

// ===== sv/track_format_stream_parser.sv =====
// Track format stream parser.
// Input channel in_*: one template byte per word, in_tdata[7:0] = data_byte.
// Result channel out_*: zero or one word per input byte. out_tuser[0] = kind
// (data capture or sector commit); out_tdata holds sector_number [7:0],
// byte_offset [16:8], byte_value [24:17], zero padding [31:25].
// Path: an accepted byte lands in the input register, is parsed from there and
// its result loads into the result register that drives out_tvalid; a held
// result register keeps the byte waiting in the input register.
// Throughput: one byte per cycle while the result register is not held. The
// input register and the result register form a two-deep pipeline; the
// parse logic (mark decode, ID/data counters) sits between them and updates
// its state in the same cycle the result loads. Bytes with no result also pass.
// Stall: when the result register holds a word that out_tready does not take,
// the pipeline holds; the input register still takes one more byte, after
// which in_tready drops until the receiver frees the result register.
// Reset (rst_n low, synchronous): both stages empty, no sync seen, no ID or
// data field open, sector number and counters cleared to zero.
`include "track_format_stream_parser_defines.svh"

module track_format_stream_parser #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] sector_number, [16:8] byte_offset,
                                  // [24:17] byte_value, [31:25] zero
  output logic [0:0]  out_tuser   // [0] kind: 0 data capture, 1 sector commit
);

  localparam int unsigned CNT_W = $clog2(SECTOR_BYTES + 1);
  localparam logic [CNT_W-1:0] SECT_FULL = CNT_W'(SECTOR_BYTES);

  // Pipeline registers
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r,  s1_byte_nxt;
  logic             out_valid_r, out_valid_nxt;
  tfsp_pkg::kind_t  out_kind_r,  out_kind_nxt;
  tfsp_pkg::result_t out_res_r,  out_res_nxt;

  // Parser state
  logic             sync_seen_r,   sync_seen_nxt;
  logic             id_active_r,   id_active_nxt;
  logic [2:0]       id_count_r,    id_count_nxt;
  logic [7:0]       id_record_r,   id_record_nxt;
  logic [7:0]       cur_sector_r,  cur_sector_nxt;
  logic             data_active_r, data_active_nxt;
  logic [CNT_W-1:0] data_count_r,  data_count_nxt;

  logic             advance;      // result register free for the next parse
  logic             in_fire;
  logic             parse;        // a byte is parsed this cycle
  logic             emit;
  tfsp_pkg::kind_t  emit_kind;
  logic [CNT_W+8:0] count_ext;
  logic [2:0]       id_count_inc;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign parse     = s1_valid_r && advance;

  // Captured byte's offset, zero-extended; its low nine bits give the offset
  assign count_ext    = {9'd0, data_count_r};
  assign id_count_inc = id_count_r + 3'd1;

  // Input register: load on accept, drain when the parse stage moves
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_tdata;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Parse one byte: mark decode, then ID field, then data field
  always_comb begin
    sync_seen_nxt   = sync_seen_r;
    id_active_nxt   = id_active_r;
    id_count_nxt    = id_count_r;
    id_record_nxt   = id_record_r;
    cur_sector_nxt  = cur_sector_r;
    data_active_nxt = data_active_r;
    data_count_nxt  = data_count_r;
    emit            = 1'b0;
    emit_kind       = tfsp_pkg::KIND_DATA;
    if (parse) begin
      if (s1_byte_r == tfsp_pkg::MARK_SYNC) begin
        sync_seen_nxt = 1'b1;
      end else begin
        sync_seen_nxt = 1'b0;
        if (sync_seen_r && s1_byte_r == tfsp_pkg::MARK_ID) begin
          id_active_nxt = 1'b1;
          id_count_nxt  = 3'd0;
        end else if (sync_seen_r && (s1_byte_r == tfsp_pkg::MARK_DATA ||
                                     s1_byte_r == tfsp_pkg::MARK_DATA_DEL)) begin
          data_active_nxt = 1'b1;
          data_count_nxt  = '0;
        end else if (id_active_r) begin
          if (id_count_r == tfsp_pkg::ID_RECORD_POS) begin
            id_record_nxt = s1_byte_r;
          end
          id_count_nxt = id_count_inc;
          // Record byte is already held when the last ID byte arrives
          if (id_count_inc >= tfsp_pkg::ID_LEN) begin
            cur_sector_nxt = id_record_r;
            id_active_nxt  = 1'b0;
          end
        end else if (data_active_r) begin
          if (s1_byte_r == tfsp_pkg::MARK_CRC && data_count_r >= SECT_FULL) begin
            data_active_nxt = 1'b0;
            emit            = 1'b1;
            emit_kind       = tfsp_pkg::KIND_COMMIT;
          end else if (data_count_r < SECT_FULL) begin
            emit           = 1'b1;
            data_count_nxt = data_count_r + 1'b1;
          end else begin
            data_count_nxt = SECT_FULL;
          end
        end
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_res_nxt   = out_res_r;
    if (advance) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_kind_nxt              = emit_kind;
        out_res_nxt.sector_number = cur_sector_r;
        if (emit_kind == tfsp_pkg::KIND_COMMIT) begin
          out_res_nxt.byte_offset = 9'd0;
          out_res_nxt.byte_value  = 8'd0;
        end else begin
          out_res_nxt.byte_offset = count_ext[8:0];
          out_res_nxt.byte_value  = s1_byte_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      sync_seen_r   <= 1'b0;
      id_active_r   <= 1'b0;
      id_count_r    <= 3'd0;
      id_record_r   <= 8'd0;
      cur_sector_r  <= 8'd0;
      data_active_r <= 1'b0;
      data_count_r  <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      sync_seen_r   <= sync_seen_nxt;
      id_active_r   <= id_active_nxt;
      id_count_r    <= id_count_nxt;
      id_record_r   <= id_record_nxt;
      cur_sector_r  <= cur_sector_nxt;
      data_active_r <= data_active_nxt;
      data_count_r  <= data_count_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    s1_byte_r  <= s1_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_kind_r;
  assign out_tdata    = {{(tfsp_pkg::OUT_TDATA_W - $bits(tfsp_pkg::result_t)){1'b0}},
                         out_res_r};

  // Checks
  `TFSP_ASSERT_NOW(a_commit_zero_fields,
    out_valid_r && out_kind_r == tfsp_pkg::KIND_COMMIT,
    out_res_r.byte_offset == 9'd0 && out_res_r.byte_value == 8'd0,
    "commit word carries nonzero offset or value")
  `TFSP_ASSERT_NOW(a_id_count_bound,
    id_active_r,
    id_count_r < tfsp_pkg::ID_LEN,
    "ID field open with a full byte count")
  `TFSP_ASSERT_NOW(a_full_pipe_blocks,
    s1_valid_r && out_valid_r && !out_tready,
    !in_tready,
    "input taken while both stages are held")
  `TFSP_ASSERT_NEXT(a_count_saturates,
    data_count_r == SECT_FULL,
    data_count_r == SECT_FULL || data_count_r == '0,
    "data count left saturation other than by a new data mark")

endmodule

// ===== verif/tb_track_format_stream_parser.sv =====
module tb_track_format_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam logic [7:0]  GAP_FILL     = 8'h4E;   // usual gap filler of a track template
  localparam int unsigned HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int unsigned TOTAL_ITEMS  = 1850;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expected result word: kind on tuser, the rest on tdata.
  typedef struct packed {
    tfsp_pkg::kind_t   kind;
    tfsp_pkg::result_t word;
  } sector_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [7:0] sector_number, [16:8] byte_offset,
                                     // [24:17] byte_value, [31:25] zero
  logic [0:0]  out_tuser;            // [0] kind

  // Words still owed by the block, oldest first.
  sector_result_t pending_words[$];
  sector_result_t oldest;
  int unsigned    mismatches = 0;
  int unsigned    items_sent = 0;

  // Sender and receiver idling controls.
  bit          tx_gaps       = 1'b1;
  int unsigned burst_left    = 0;
  bit          rx_stalls     = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_started = 0;
  int unsigned hold_left     = 0;
  int unsigned run_left      = 0;

  // Parser state as seen from the byte stream; reset values match the block.
  bit          fmt_sync    = 1'b0;
  bit          fmt_in_id   = 1'b0;
  int unsigned fmt_id_seen = 0;
  logic [7:0]  fmt_record  = 8'h00;
  logic [7:0]  fmt_sector  = 8'h00;
  bit          fmt_in_data = 1'b0;
  int unsigned fmt_taken   = 0;

  track_format_stream_parser #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Advance the format parser by one template byte; return 1 when the byte
  // yields a word, which is placed in res.
  function automatic bit parse_template_byte(input logic [7:0] b, output sector_result_t res);
    bit after_sync;
    res = '0;
    // A sync is never stored, and a run of them counts as one.
    if (b == tfsp_pkg::MARK_SYNC) begin
      fmt_sync = 1'b1;
      return 1'b0;
    end
    after_sync = fmt_sync;
    fmt_sync   = 1'b0;
    // Marks right after a sync win over any open field.
    if (after_sync && b == tfsp_pkg::MARK_ID) begin
      fmt_in_id   = 1'b1;
      fmt_id_seen = 0;
      return 1'b0;
    end
    if (after_sync && (b == tfsp_pkg::MARK_DATA || b == tfsp_pkg::MARK_DATA_DEL)) begin
      fmt_in_data = 1'b1;
      fmt_taken   = 0;
      return 1'b0;
    end
    // An open ID field takes the byte before an open data field does.
    if (fmt_in_id) begin
      if (fmt_id_seen == tfsp_pkg::ID_RECORD_POS) fmt_record = b;
      fmt_id_seen++;
      if (fmt_id_seen >= tfsp_pkg::ID_LEN) begin
        fmt_sector = fmt_record;
        fmt_in_id  = 1'b0;
      end
      return 1'b0;
    end
    if (fmt_in_data) begin
      // CRC mark only commits once the whole sector has been taken.
      if (b == tfsp_pkg::MARK_CRC && fmt_taken >= SECTOR_BYTES) begin
        fmt_in_data              = 1'b0;
        res.kind                 = tfsp_pkg::KIND_COMMIT;
        res.word.sector_number   = fmt_sector;
        return 1'b1;
      end
      if (fmt_taken < SECTOR_BYTES) begin
        res.kind               = tfsp_pkg::KIND_DATA;
        res.word.sector_number = fmt_sector;
        res.word.byte_offset   = fmt_taken[8:0];
        res.word.byte_value    = b;
        fmt_taken++;
        return 1'b1;
      end
      // Over-long field: drop the byte, count stays saturated.
      return 1'b0;
    end
    return 1'b0;
  endfunction

  // Receiver: long hold-off on request, else a random ready/stall pattern.
  always @(posedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!rx_stalls) begin
      out_tready <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else begin
      // Flip between a ready run and a short stall.
      out_tready <= ~out_tready;
      run_left   <= out_tready ? $urandom_range(0, 4) : $urandom_range(1, 12);
    end
  end

  // Check every word the block hands over against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word: kind=%0d sector=%0h offset=%0d value=%0h",
                   $realtime, out_tuser[0], out_tdata[7:0], out_tdata[16:8], out_tdata[24:17]);
      end else begin
        oldest = pending_words.pop_front();
        if (out_tuser[0] !== oldest.kind ||
            out_tdata[7:0] !== oldest.word.sector_number ||
            out_tdata[16:8] !== oldest.word.byte_offset ||
            out_tdata[24:17] !== oldest.word.byte_value ||
            out_tdata[31:25] !== 7'd0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: word mismatch: expected kind=%0d sector=%0h offset=%0d value=%0h",
                     $realtime, oldest.kind, oldest.word.sector_number,
                     oldest.word.byte_offset, oldest.word.byte_value);
            $display("%0t:   got kind=%0d sector=%0h offset=%0d value=%0h pad=%0h",
                     $realtime, out_tuser[0], out_tdata[7:0], out_tdata[16:8],
                     out_tdata[24:17], out_tdata[31:25]);
          end
        end
      end
    end
  end

  // Offer one template byte and hold it until the block takes it. With tx_gaps
  // set, the sender runs in bursts of random length with idle gaps in between.
  task automatic send_byte(input logic [7:0] b);
    sector_result_t res;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (parse_template_byte(b, res)) pending_words.insert(pending_words.size(), res);
  endtask

  // Stop offering and wait for every owed word, then let the pipe settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly random byte, often one of the marks.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0:       return tfsp_pkg::MARK_SYNC;
      1:       return tfsp_pkg::MARK_ID;
      2:       return tfsp_pkg::MARK_DATA;
      3:       return tfsp_pkg::MARK_DATA_DEL;
      4:       return tfsp_pkg::MARK_CRC;
      default: return 8'($urandom);
    endcase
  endfunction

  // Bytes outside any field and a sync followed by a non-mark give nothing.
  task automatic test_stray_bytes();
    logic [7:0] seq[];
    seq = '{8'h00, 8'hFF, tfsp_pkg::MARK_ID, tfsp_pkg::MARK_DATA, tfsp_pkg::MARK_CRC,
            tfsp_pkg::MARK_SYNC, GAP_FILL};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // ID and data marks, repeated syncs, early CRC mark, deleted-data mark,
  // a lone sync inside a field, and an ID field opened inside a data field.
  task automatic test_fields_and_marks();
    logic [7:0] seq[];
    seq = '{tfsp_pkg::MARK_SYNC, tfsp_pkg::MARK_SYNC, tfsp_pkg::MARK_SYNC,
            tfsp_pkg::MARK_ID, 8'h00, 8'h01, 8'hFF, 8'h02,
            tfsp_pkg::MARK_SYNC, tfsp_pkg::MARK_DATA, 8'h00, 8'hFF, tfsp_pkg::MARK_CRC,
            tfsp_pkg::MARK_SYNC, tfsp_pkg::MARK_DATA_DEL, 8'hA5,
            tfsp_pkg::MARK_SYNC, 8'h5A,
            tfsp_pkg::MARK_SYNC, tfsp_pkg::MARK_ID, 8'h01, 8'h00, 8'h00, 8'h02,
            8'h33};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Full sector, over-long tail, commit, then a stray CRC mark. The receiver
  // holds off for a long stretch while the sender runs flat out, so the
  // block fills and stalls its input.
  task automatic test_sector_commit();
    logic [7:0] b;
    tx_gaps = 1'b0;
    hold_requests <= hold_requests + 1;
    send_byte(tfsp_pkg::MARK_SYNC);
    send_byte(tfsp_pkg::MARK_ID);
    repeat (2) send_byte(8'($urandom));
    send_byte(8'($urandom_range(1, 254)));
    send_byte(8'($urandom));
    send_byte(tfsp_pkg::MARK_SYNC);
    send_byte(tfsp_pkg::MARK_DATA);
    repeat (SECTOR_BYTES) begin
      b = 8'($urandom);
      if (b == tfsp_pkg::MARK_SYNC) b = ~b;
      send_byte(b);
    end
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tfsp_pkg::MARK_CRC);
    send_byte(tfsp_pkg::MARK_CRC);
    tx_gaps = 1'b1;
  endtask

  // One record of a random track: mostly well-formed ID and data fields with
  // random content, some truncated or broken, some plain noise.
  task automatic send_record();
    int unsigned pick;
    int unsigned len;
    bit          full;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 24)) send_byte(noise_byte());
      return;
    end
    repeat ($urandom_range(0, 4)) send_byte($urandom_range(0, 1) ? GAP_FILL : 8'($urandom));
    repeat ($urandom_range(1, 3)) send_byte(tfsp_pkg::MARK_SYNC);
    // Broken ID mark on a few records.
    send_byte(pick < 16 ? 8'($urandom) : tfsp_pkg::MARK_ID);
    repeat (pick < 22 ? $urandom_range(0, 3) : 4) send_byte(8'($urandom));
    repeat ($urandom_range(0, 2)) send_byte(GAP_FILL);
    repeat ($urandom_range(1, 3)) send_byte(tfsp_pkg::MARK_SYNC);
    send_byte($urandom_range(0, 1) ? tfsp_pkg::MARK_DATA : tfsp_pkg::MARK_DATA_DEL);
    full = ($urandom_range(0, 99) < 18);
    len  = full ? SECTOR_BYTES + $urandom_range(0, 3) : $urandom_range(1, 48);
    repeat (len) begin
      b = 8'($urandom);
      if (full && b == tfsp_pkg::MARK_SYNC) b = ~b;
      if (!full && $urandom_range(0, 15) == 0) b = tfsp_pkg::MARK_CRC;
      send_byte(b);
    end
    if ($urandom_range(0, 4) != 0) send_byte(tfsp_pkg::MARK_CRC);
  endtask

  // Random track up to the overall item budget; idling switches per record.
  task automatic test_random_track();
    while (items_sent < TOTAL_ITEMS) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls <= ($urandom_range(0, 3) != 0);
      send_record();
    end
  endtask

  initial begin
    // Hold reset at the start, then run each test in turn.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_stray_bytes();
    test_fields_and_marks();
    wait_drained();
    test_sector_commit();
    wait_drained();
    test_random_track();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_track_format_stream_parser: PASS");
    end else begin
      $display("tb_track_format_stream_parser: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_track_format_stream_parser: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tfsp_pkg.sv
sv/track_format_stream_parser.sv
verif/tb_track_format_stream_parser.sv
